FILE: hdl/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and codes for the range set boundary table.
// ----------------------------------------------------------------------------
package rsb_pkg;

    localparam int DEF_MAX_BOUNDARIES = 64;
    localparam int DEF_POSITION_WIDTH = 31;

    localparam int FIELD_POS_W = 31;
    localparam int IDX_OUT_W   = 13;
    localparam int USED_W      = 13;
    localparam int STATUS_W    = 2;
    localparam int KIND_W      = 2;

    localparam logic [KIND_W-1:0] K_FLIP   = 2'd0;
    localparam logic [KIND_W-1:0] K_LOCATE = 2'd1;
    localparam logic [KIND_W-1:0] K_INSERT = 2'd2;
    localparam logic [KIND_W-1:0] K_DELETE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic shift;
        logic commit;
    } t_cell_ctl;

    typedef struct packed {
        logic start;
        logic feed;
        logic flush;
        logic fin;
    } t_strm_ctl;

endpackage

FILE: hdl/rsb_cell.sv
// ----------------------------------------------------------------------------
// rsb_cell
// One boundary cell: the live entry rotates to the neighbor, the rebuilt
// entry is written by index and copied over on commit.
// ----------------------------------------------------------------------------
module rsb_cell
    import rsb_pkg::*;
#(
    parameter int PW = DEF_POSITION_WIDTH
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [PW-1:0] i_cur_nb,
    input  logic          i_wr_en,
    input  logic [PW-1:0] i_wr_data,
    output logic [PW-1:0] o_cur
);

    logic [PW-1:0] r_cur;
    logic [PW-1:0] r_nxt;
    logic [PW-1:0] n_cur;

    always_comb begin
        n_cur = r_cur;
        if (i_ctl.shift) begin
            n_cur = i_cur_nb;
        end else if (i_ctl.commit) begin
            n_cur = r_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_wr_en) begin
            r_nxt <= i_wr_data;
        end
    end

    assign o_cur = r_cur;

endmodule

FILE: hdl/rsb_stream.sv
// ----------------------------------------------------------------------------
// rsb_stream
// Boundary stream unit: maps each old entry, cancels equal pairs, merges
// the two toggle points and emits up to three new entries a cycle.
// Also accumulates the locate index and rank.
// ----------------------------------------------------------------------------
module rsb_stream
    import rsb_pkg::*;
#(
    parameter int PW  = DEF_POSITION_WIDTH,
    parameter int CNW = 7,
    parameter int WCW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_strm_ctl            i_ctl,
    input  logic [PW-1:0]        i_head,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [PW-1:0]        i_off,
    input  logic [PW-1:0]        i_eff,
    input  logic [PW-1:0]        i_end,
    input  logic                 i_mode,
    output logic [1:0]           o_wr_n,
    output logic [2:0][PW-1:0]   o_wr_data,
    output logic [WCW-1:0]       o_wr_base,
    output logic [IDX_OUT_W-1:0] o_index,
    output logic [PW-1:0]        o_rank
);

    localparam logic [PW-1:0] POS_MAX = '1;

    logic          r_av, r_hv, r_par;
    logic [PW-1:0] r_a, r_h, r_last, r_fill;
    logic [1:0]    r_p;
    logic [WCW-1:0] r_w;
    logic [CNW-1:0] r_le;

    logic          n_av, n_hv, n_par;
    logic [PW-1:0] n_a, n_h;
    logic [1:0]    n_p;
    logic [PW-1:0] map_v;
    logic          bv;
    logic [PW-1:0] b;
    logic          miss, en;
    logic [1:0]    k;
    logic [2:0][PW-1:0] wd;
    logic [PW-1:0] fill_k;

    // map one old entry
    always_comb begin
        map_v = i_head;
        if (i_kind == K_INSERT) begin
            if (i_head > i_off) begin
                map_v = (i_head > POS_MAX - i_eff) ? POS_MAX : i_head + i_eff;
            end
        end else if (i_kind == K_DELETE) begin
            if (i_head > i_end) begin
                map_v = i_head - i_eff;
            end else if (i_head >= i_off) begin
                map_v = i_off;
            end
        end
    end

    assign n_av = i_ctl.feed;
    assign n_a  = map_v;

    // cancel equal neighbors in pairs
    always_comb begin
        bv   = 1'b0;
        b    = r_h;
        n_hv = r_hv;
        n_h  = r_h;
        if (r_av) begin
            if (r_hv && r_h == r_a) begin
                n_hv = 1'b0;
            end else begin
                bv   = r_hv;
                n_hv = 1'b1;
                n_h  = r_a;
            end
        end else if (i_ctl.flush) begin
            bv   = r_hv;
            n_hv = 1'b0;
        end
    end

    // merge the toggle points off and end into the stream
    always_comb begin
        k     = 2'd0;
        wd    = '0;
        n_p   = r_p;
        n_par = r_par;
        if (bv) begin
            miss = ~(r_par ^ (b == i_off));
        end else begin
            miss = ~r_par;
        end
        if (i_kind == K_FLIP) begin
            en = 1'b1;
        end else if (i_kind == K_INSERT) begin
            en = (i_mode == miss);
        end else begin
            en = 1'b0;
        end
        if (bv) begin
            if (b <= i_off) begin
                n_par = ~r_par;
            end
            if (r_p == 2'd0 && b < i_off) begin
                wd[k] = b; k = k + 2'd1;
            end else if (r_p == 2'd0 && !en) begin
                n_p = 2'd2;
                wd[k] = b; k = k + 2'd1;
            end else if (r_p == 2'd0 && b == i_off) begin
                n_p = 2'd1;
            end else if (r_p == 2'd2) begin
                wd[k] = b; k = k + 2'd1;
            end else begin
                if (r_p == 2'd0) begin
                    wd[k] = i_off; k = k + 2'd1;
                end
                if (b < i_end) begin
                    n_p = 2'd1;
                    wd[k] = b; k = k + 2'd1;
                end else if (b == i_end) begin
                    n_p = 2'd2;
                end else begin
                    n_p = 2'd2;
                    wd[k] = i_end; k = k + 2'd1;
                    wd[k] = b; k = k + 2'd1;
                end
            end
        end else if (i_ctl.fin) begin
            n_p = 2'd2;
            if (r_p == 2'd0 && en) begin
                wd[k] = i_off; k = k + 2'd1;
                wd[k] = i_end; k = k + 2'd1;
            end else if (r_p == 2'd1) begin
                wd[k] = i_end; k = k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_av  <= 1'b0;
            r_hv  <= 1'b0;
            r_par <= 1'b0;
            r_p   <= 2'd0;
            r_w   <= '0;
            r_le  <= '0;
        end else begin
            r_av  <= n_av;
            r_hv  <= n_hv;
            r_par <= n_par;
            r_p   <= n_p;
            r_w   <= r_w + WCW'(k);
            if (i_ctl.feed && i_off >= i_head) begin
                r_le <= r_le + CNW'(1);
            end
        end
        r_a <= n_a;
        r_h <= n_h;
        if (i_ctl.start) begin
            r_last <= '0;
            r_fill <= '0;
        end else if (i_ctl.feed && i_off >= i_head) begin
            r_last <= i_head;
            if (r_le[0]) begin
                r_fill <= r_fill + (i_head - r_last);
            end
        end
    end

    assign fill_k    = r_le[0] ? r_fill : r_last - r_fill;
    assign o_rank    = fill_k + i_off - r_last;
    assign o_index   = IDX_OUT_W'(r_le) - IDX_OUT_W'(1);
    assign o_wr_n    = k;
    assign o_wr_data = wd;
    assign o_wr_base = r_w;

endmodule

FILE: hdl/range_set_boundary_table.sv
// ----------------------------------------------------------------------------
// range_set_boundary_table
// Sorted boundary table with flip, locate, insert and delete of runs.
// ----------------------------------------------------------------------------
// A result word follows one full rotation of the cell ring, the tail, flush
// and final drain states, and the commit into the output register.
// Zero-length insert, delete or flip skips the ring and goes straight to done.
// A new word is taken only in the idle state, so not before the previous
// result word is loaded; a stalled result word holds the input.
// Reset (synchronous, active low) empties the table and the output stage.
module range_set_boundary_table
    import rsb_pkg::*;
#(
    parameter int MAX_BOUNDARIES = DEF_MAX_BOUNDARIES,
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // position[30:0], run_length[61:31], insert_in_range[62], zero[63]
    input  logic [63:0]       i_s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0] i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // boundary_index[12:0], rank_offset[43:13], boundaries_used[56:44],
    // status[58:57], zero[63:59]
    output logic [63:0]       o_m_tdata
);

    localparam int N     = MAX_BOUNDARIES;
    localparam int PW    = POSITION_WIDTH;
    localparam int CNW   = $clog2(N + 1);
    localparam int IXW   = $clog2(N);
    localparam int WCW   = $clog2(N + 3);
    localparam logic [PW-1:0] POS_MAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state;
    logic [IXW-1:0]      r_step;
    logic [CNW-1:0]      r_count;
    logic                r_quick;
    logic [STATUS_W-1:0] r_qstatus;
    logic [KIND_W-1:0]   r_kind;
    logic [PW-1:0]       r_off, r_eff, r_end;
    logic                r_mode;
    logic                r_out_valid;
    logic [63:0]         r_out;

    logic [FIELD_POS_W-1:0] in_pos, in_len;
    logic [PW-1:0]       c_off, c_len, c_room, c_eff;
    logic                accept, load_out, fits, do_commit;
    logic [CNW-1:0]      new_count;
    logic [STATUS_W-1:0] res_status;
    logic [IDX_OUT_W-1:0] res_index;
    logic [FIELD_POS_W-1:0] res_rank;

    t_cell_ctl           c_ctl;
    t_strm_ctl           s_ctl;
    logic [PW-1:0]       cur [N];
    logic [1:0]          wr_n;
    logic [2:0][PW-1:0]  wr_data;
    logic [WCW-1:0]      wr_base;
    logic [IDX_OUT_W-1:0] st_index;
    logic [PW-1:0]       st_rank;

    assign in_pos = i_s_tdata[30:0];
    assign in_len = i_s_tdata[61:31];
    assign c_off  = (in_pos > FIELD_POS_W'(POS_MAX)) ? POS_MAX : in_pos[PW-1:0];
    assign c_len  = (in_len > FIELD_POS_W'(POS_MAX)) ? POS_MAX : in_len[PW-1:0];
    assign c_room = POS_MAX - c_off;
    assign c_eff  = (c_len > c_room) ? c_room : c_len;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign fits      = (wr_base <= WCW'(N));
    assign do_commit = load_out && !r_quick && r_kind != K_LOCATE
                       && (r_kind == K_DELETE || fits);
    assign new_count = do_commit ? CNW'(wr_base) : r_count;

    always_comb begin
        res_status = ST_OK;
        res_index  = '0;
        res_rank   = '0;
        if (r_quick) begin
            res_status = r_qstatus;
        end else if (r_kind == K_LOCATE) begin
            res_index = st_index;
            res_rank  = FIELD_POS_W'(st_rank);
        end else if (r_kind != K_DELETE && !fits) begin
            res_status = ST_FULL;
        end
    end

    assign c_ctl.shift  = (r_state == S_RUN);
    assign c_ctl.commit = do_commit;
    assign s_ctl.start  = accept;
    assign s_ctl.feed   = (r_state == S_RUN) && (CNW'(r_step) < r_count);
    assign s_ctl.flush  = (r_state == S_FLUSH);
    assign s_ctl.fin    = (r_state == S_FINAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= new_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_step <= '0;
                        if (i_s_tuser != K_LOCATE && c_eff == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_step <= r_step + IXW'(1);
                    if (r_step == IXW'(N - 1)) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL:  r_state <= S_FLUSH;
                S_FLUSH: r_state <= S_FINAL;
                S_FINAL: r_state <= S_DONE;
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_s_tuser;
            r_off     <= c_off;
            r_eff     <= c_eff;
            r_end     <= c_off + c_eff;
            r_mode    <= i_s_tdata[62];
            r_quick   <= (i_s_tuser != K_LOCATE && c_eff == '0);
            r_qstatus <= (i_s_tuser == K_FLIP) ? ST_OK : ST_ZERO;
        end
        if (load_out) begin
            r_out <= {5'd0, res_status, USED_W'(new_count), res_rank, res_index};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // ring of cells; the head feeds the stream unit
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        logic          wen;
        logic [PW-1:0] wdat;

        always_comb begin
            wen  = 1'b0;
            wdat = wr_data[0];
            if (wr_n > 2'd0 && wr_base == WCW'(gi)) begin
                wen  = 1'b1;
                wdat = wr_data[0];
            end else if (wr_n > 2'd1 && wr_base + WCW'(1) == WCW'(gi)) begin
                wen  = 1'b1;
                wdat = wr_data[1];
            end else if (wr_n > 2'd2 && wr_base + WCW'(2) == WCW'(gi)) begin
                wen  = 1'b1;
                wdat = wr_data[2];
            end
        end

        rsb_cell #(.PW(PW)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (c_ctl),
            .i_cur_nb  (cur[(gi + 1) % N]),
            .i_wr_en   (wen),
            .i_wr_data (wdat),
            .o_cur     (cur[gi])
        );
    end

    rsb_stream #(.PW(PW), .CNW(CNW), .WCW(WCW)) u_stream (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s_ctl),
        .i_head    (cur[0]),
        .i_kind    (r_kind),
        .i_off     (r_off),
        .i_eff     (r_eff),
        .i_end     (r_end),
        .i_mode    (r_mode),
        .o_wr_n    (wr_n),
        .o_wr_data (wr_data),
        .o_wr_base (wr_base),
        .o_index   (st_index),
        .o_rank    (st_rank)
    );

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(N))
        else $error("boundary count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("word accepted while previous one in flight");

    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl.commit |-> (wr_base <= WCW'(N)))
        else $error("commit of an overfull table");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result word outside completion");

endmodule
